@@ src/nvs_pkg.sv @@
// shared types and constants for the named vector store
`timescale 1ns / 1ps
package nvs_pkg;

    localparam int KEY_W      = 63;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 5;
    localparam int LIST_MAX   = 16;
    localparam int LIST_CNT_W = 5;

    localparam logic [2:0] CMD_DEFINE = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_SUB    = 3'd2;
    localparam logic [2:0] CMD_SCALE  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
    localparam logic [2:0] CMD_SHOW   = 3'd5;
    localparam logic [2:0] CMD_LIST   = 3'd6;
    localparam logic [2:0] CMD_BAD    = 3'd7;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_NOTFOUND = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_BADCMD   = 3'd4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]               cmd;
        logic [KEY_W-1:0]         dest_key;
        logic [KEY_W-1:0]         src_a_key;
        logic [KEY_W-1:0]         src_b_key;
        logic signed [DATA_W-1:0] val_x;
        logic signed [DATA_W-1:0] val_y;
        logic signed [DATA_W-1:0] val_z;
        logic signed [DATA_W-1:0] factor;
    } nvs_in_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [3:0]               slot_index;
        logic [KEY_W-1:0]         out_key;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     last;
    } nvs_out_t;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } nvs_entry_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last_bit;
        logic mul;
        logic sub;
    } nvs_lane_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_CALC_LOAD,
        S_CALC,
        S_CALC_DONE,
        S_WRITE,
        S_OUT,
        S_LIST,
        S_LIST_RD
    } nvs_state_t;

    typedef enum logic [1:0] {
        SP_A,
        SP_B,
        SP_DEST
    } nvs_purpose_t;

endpackage

@@ src/nvs_lane.sv @@
// bit-serial add/subtract and shift-add multiply for one vector component
`timescale 1ns / 1ps
module nvs_lane
    import nvs_pkg::*;
(
    input  logic                     clk,
    input  nvs_lane_ctl_t            ctl,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic signed [DATA_W-1:0] res
);

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] acc_hi_reg;
    logic [DATA_W-1:0] acc_lo_reg;
    logic              carry_reg;
    logic              ext_reg;

    logic              bb;
    logic              s;
    logic              cy;
    logic [DATA_W-1:0] addend;
    logic [DATA_W:0]   hi_sum;
    logic [2*DATA_W-1:0] prod;
    logic              fits;

    assign bb     = b_reg[0] ^ ctl.sub;
    assign s      = a_reg[0] ^ bb ^ carry_reg;
    assign cy     = (a_reg[0] & bb) | (a_reg[0] & carry_reg) | (bb & carry_reg);
    assign addend = b_reg[0] ? a_reg : '0;
    // the top factor bit carries negative weight
    assign hi_sum = ctl.last_bit
                  ? {acc_hi_reg[DATA_W-1], acc_hi_reg} - {addend[DATA_W-1], addend}
                  : {acc_hi_reg[DATA_W-1], acc_hi_reg} + {addend[DATA_W-1], addend};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg      <= a;
            b_reg      <= b;
            acc_hi_reg <= '0;
            acc_lo_reg <= '0;
            carry_reg  <= ctl.sub;
            ext_reg    <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.mul)
            begin
                acc_hi_reg <= hi_sum[DATA_W:1];
                acc_lo_reg <= {hi_sum[0], acc_lo_reg[DATA_W-1:1]};
                b_reg      <= {1'b0, b_reg[DATA_W-1:1]};
            end
            else
            begin
                a_reg      <= {1'b0, a_reg[DATA_W-1:1]};
                b_reg      <= {1'b0, b_reg[DATA_W-1:1]};
                carry_reg  <= cy;
                acc_lo_reg <= {s, acc_lo_reg[DATA_W-1:1]};
                if (ctl.last_bit)
                begin
                    ext_reg <= a_reg[0] ^ bb ^ cy;
                end
            end
        end
    end

    // floor of product / 2^16 is the arithmetic shift
    assign prod = {acc_hi_reg, acc_lo_reg};
    assign fits = (&prod[2*DATA_W-1:DATA_W+15]) | ~(|prod[2*DATA_W-1:DATA_W+15]);

    always_comb
    begin
        if (ctl.mul)
        begin
            if (fits)
            begin
                res = prod[DATA_W+15:16];
            end
            else
            begin
                res = prod[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
        else
        begin
            if (ext_reg != acc_lo_reg[DATA_W-1])
            begin
                res = ext_reg ? SAT_MIN : SAT_MAX;
            end
            else
            begin
                res = acc_lo_reg;
            end
        end
    end

endmodule

@@ src/named_vector_store_alu.sv @@
// named vector store: key search, bit-serial arithmetic and result sequencing
// a search skips unused slots and reads and compares the name in each used slot;
// add, subtract and scale add bit-serial arithmetic in the lanes, then a write
// list skips unused slots and reads and reports each used slot, up to 16 results
// one command in flight at a time; the next is taken after the last result transfer
// reset clears all used marks at once; names and components are not cleared
`timescale 1ns / 1ps
module named_vector_store_alu
    import nvs_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  nvs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output nvs_out_t out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // control state
    nvs_state_t          state_reg, state_next;
    nvs_purpose_t        purpose_reg, purpose_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                free_found_reg, free_found_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LIST_CNT_W-1:0] list_n_reg, list_n_next;

    // payload
    logic [2:0]               cmd_reg, cmd_next;
    logic [KEY_W-1:0]         dest_reg, dest_next;
    logic [KEY_W-1:0]         ka_reg, ka_next;
    logic [KEY_W-1:0]         kb_reg, kb_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic signed [DATA_W-1:0] fac_reg, fac_next;
    logic signed [DATA_W-1:0] res_x_reg, res_x_next;
    logic signed [DATA_W-1:0] res_y_reg, res_y_next;
    logic signed [DATA_W-1:0] res_z_reg, res_z_next;
    logic signed [DATA_W-1:0] opa_x_reg, opa_x_next;
    logic signed [DATA_W-1:0] opa_y_reg, opa_y_next;
    logic signed [DATA_W-1:0] opa_z_reg, opa_z_next;
    logic signed [DATA_W-1:0] opb_x_reg, opb_x_next;
    logic signed [DATA_W-1:0] opb_y_reg, opb_y_next;
    logic signed [DATA_W-1:0] opb_z_reg, opb_z_next;
    logic [IW-1:0]            free_idx_reg, free_idx_next;
    logic [IW-1:0]            wr_idx_reg, wr_idx_next;
    nvs_out_t                 out_reg, out_next;

    // slot memory, one read and one write port, registered read
    nvs_entry_t mem [SLOTS];
    nvs_entry_t mem_q_reg;
    logic       mem_re;
    logic       mem_we;
    nvs_entry_t mem_wdata;

    // bit-serial lanes
    nvs_lane_ctl_t            lane_ctl;
    logic signed [DATA_W-1:0] lane_bx, lane_by, lane_bz;
    logic signed [DATA_W-1:0] lane_rx, lane_ry, lane_rz;

    logic [SLOTS-1:0] above_mask;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    assign lane_bx = (cmd_reg == CMD_SCALE) ? fac_reg : opb_x_reg;
    assign lane_by = (cmd_reg == CMD_SCALE) ? fac_reg : opb_y_reg;
    assign lane_bz = (cmd_reg == CMD_SCALE) ? fac_reg : opb_z_reg;

    nvs_lane u_lane_x (.clk(clk), .ctl(lane_ctl), .a(opa_x_reg), .b(lane_bx), .res(lane_rx));
    nvs_lane u_lane_y (.clk(clk), .ctl(lane_ctl), .a(opa_y_reg), .b(lane_by), .res(lane_ry));
    nvs_lane u_lane_z (.clk(clk), .ctl(lane_ctl), .a(opa_z_reg), .b(lane_bz), .res(lane_rz));

    // slots above the current list position
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            above_mask[i] = (IW'(i) > idx_reg) && (i < SLOTS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        logic       srch_hit;
        logic       srch_miss;
        logic       srch_adv;
        logic       free_any;
        logic [IW-1:0] free_pick;
        logic       list_last;

        state_next      = state_reg;
        purpose_next    = purpose_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        cnt_next        = cnt_reg;
        list_n_next     = list_n_reg;
        cmd_next        = cmd_reg;
        dest_next       = dest_reg;
        ka_next         = ka_reg;
        kb_next         = kb_reg;
        key_next        = key_reg;
        fac_next        = fac_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_z_next      = res_z_reg;
        opa_x_next      = opa_x_reg;
        opa_y_next      = opa_y_reg;
        opa_z_next      = opa_z_reg;
        opb_x_next      = opb_x_reg;
        opb_y_next      = opb_y_reg;
        opb_z_next      = opb_z_reg;
        free_idx_next   = free_idx_reg;
        wr_idx_next     = wr_idx_reg;
        out_next        = out_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = '{key: dest_reg, x: res_x_reg, y: res_y_reg, z: res_z_reg};
        lane_ctl        = '{load: 1'b0, step: 1'b0, last_bit: 1'b0,
                            mul: (cmd_reg == CMD_SCALE), sub: (cmd_reg == CMD_SUB)};
        srch_hit        = 1'b0;
        srch_miss       = 1'b0;
        srch_adv        = 1'b0;
        list_last       = 1'b0;
        free_any        = free_found_reg;
        free_pick       = free_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = in_data.cmd;
                    dest_next = in_data.dest_key;
                    ka_next   = in_data.src_a_key;
                    kb_next   = in_data.src_b_key;
                    fac_next  = in_data.factor;
                    idx_next  = '0;
                    free_found_next = 1'b0;
                    case (in_data.cmd)
                        CMD_DEFINE:
                        begin
                            res_x_next   = in_data.val_x;
                            res_y_next   = in_data.val_y;
                            res_z_next   = in_data.val_z;
                            key_next     = in_data.dest_key;
                            purpose_next = SP_DEST;
                            state_next   = S_SRCH;
                        end
                        CMD_ADD, CMD_SUB, CMD_SCALE, CMD_SHOW:
                        begin
                            key_next     = in_data.src_a_key;
                            purpose_next = SP_A;
                            state_next   = S_SRCH;
                        end
                        CMD_CLEAR:
                        begin
                            used_next  = '0;
                            out_next   = '{STAT_OK, 4'd0, '0, '0, '0, '0, 1'b1};
                            state_next = S_OUT;
                        end
                        CMD_LIST:
                        begin
                            list_n_next = '0;
                            if (used_reg == '0)
                            begin
                                out_next   = '{STAT_EMPTY, 4'd0, '0, '0, '0, '0, 1'b1};
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            out_next   = '{STAT_BADCMD, 4'd0, '0, '0, '0, '0, 1'b1};
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (used_reg[idx_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                        free_any        = 1'b1;
                        free_pick       = idx_reg;
                    end
                    srch_adv = 1'b1;
                end
            end
            S_CMP:
            begin
                if (mem_q_reg.key == key_reg)
                begin
                    srch_hit = 1'b1;
                end
                else
                begin
                    srch_adv   = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_CALC_LOAD:
            begin
                lane_ctl.load = 1'b1;
                cnt_next      = '0;
                state_next    = S_CALC;
            end
            S_CALC:
            begin
                lane_ctl.step     = 1'b1;
                lane_ctl.last_bit = (cnt_reg == CNT_W'(DATA_W - 1));
                cnt_next          = cnt_reg + 1'b1;
                if (lane_ctl.last_bit)
                begin
                    state_next = S_CALC_DONE;
                end
            end
            S_CALC_DONE:
            begin
                res_x_next      = lane_rx;
                res_y_next      = lane_ry;
                res_z_next      = lane_rz;
                key_next        = dest_reg;
                purpose_next    = SP_DEST;
                idx_next        = '0;
                free_found_next = 1'b0;
                state_next      = S_SRCH;
            end
            S_WRITE:
            begin
                mem_we                = 1'b1;
                used_next[wr_idx_reg] = 1'b1;
                out_next   = '{STAT_OK, 4'(wr_idx_reg), dest_reg,
                               res_x_reg, res_y_reg, res_z_reg, 1'b1};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (cmd_reg == CMD_LIST && !out_reg.last)
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LIST:
            begin
                if (used_reg[idx_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = S_LIST_RD;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LIST_RD:
            begin
                list_last = (list_n_reg == LIST_CNT_W'(LIST_MAX - 1))
                          || ((used_reg & above_mask) == '0);
                out_next    = '{STAT_OK, 4'(idx_reg), mem_q_reg.key,
                                mem_q_reg.x, mem_q_reg.y, mem_q_reg.z, list_last};
                list_n_next = list_n_reg + 1'b1;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a slot with no match
        if (srch_adv)
        begin
            if (idx_reg == LAST_IDX)
            begin
                srch_miss = 1'b1;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_SRCH;
            end
        end

        if (srch_hit)
        begin
            case (purpose_reg)
                SP_A:
                begin
                    if (cmd_reg == CMD_SHOW)
                    begin
                        out_next   = '{STAT_OK, 4'(idx_reg), mem_q_reg.key,
                                       mem_q_reg.x, mem_q_reg.y, mem_q_reg.z, 1'b1};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        opa_x_next = mem_q_reg.x;
                        opa_y_next = mem_q_reg.y;
                        opa_z_next = mem_q_reg.z;
                        if (cmd_reg == CMD_SCALE)
                        begin
                            state_next = S_CALC_LOAD;
                        end
                        else
                        begin
                            key_next        = kb_reg;
                            purpose_next    = SP_B;
                            idx_next        = '0;
                            free_found_next = 1'b0;
                            state_next      = S_SRCH;
                        end
                    end
                end
                SP_B:
                begin
                    opb_x_next = mem_q_reg.x;
                    opb_y_next = mem_q_reg.y;
                    opb_z_next = mem_q_reg.z;
                    state_next = S_CALC_LOAD;
                end
                default:
                begin
                    wr_idx_next = idx_reg;
                    state_next  = S_WRITE;
                end
            endcase
        end
        else if (srch_miss)
        begin
            case (purpose_reg)
                SP_A, SP_B:
                begin
                    out_next   = '{STAT_NOTFOUND, 4'd0,
                                   (cmd_reg == CMD_SHOW) ? ka_reg : dest_reg,
                                   '0, '0, '0, 1'b1};
                    state_next = S_OUT;
                end
                default:
                begin
                    if (free_any)
                    begin
                        wr_idx_next = free_pick;
                        state_next  = S_WRITE;
                    end
                    else
                    begin
                        out_next   = '{STAT_FULL, 4'd0, dest_reg,
                                       res_x_reg, res_y_reg, res_z_reg, 1'b1};
                        state_next = S_OUT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            purpose_reg    <= SP_A;
            used_reg       <= '0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
            list_n_reg     <= '0;
            cmd_reg        <= CMD_DEFINE;
        end
        else
        begin
            state_reg      <= state_next;
            purpose_reg    <= purpose_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
            list_n_reg     <= list_n_next;
            cmd_reg        <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg     <= dest_next;
        ka_reg       <= ka_next;
        kb_reg       <= kb_next;
        key_reg      <= key_next;
        fac_reg      <= fac_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        opa_x_reg    <= opa_x_next;
        opa_y_reg    <= opa_y_next;
        opa_z_reg    <= opa_z_next;
        opb_x_reg    <= opb_x_next;
        opb_y_reg    <= opb_y_next;
        opb_z_reg    <= opb_z_next;
        free_idx_reg <= free_idx_next;
        wr_idx_reg   <= wr_idx_next;
        out_reg      <= out_next;
    end

endmodule

@@ dv/tb_named_vector_store_alu.sv @@
// testbench for the named vector store: directed and random commands checked by a scoreboard
`timescale 1ns / 1ps

// scoreboard: a behavioral copy of the store and a queue of expected results
class nvs_scoreboard;
    bit                       used [16];
    logic [nvs_pkg::KEY_W-1:0] name [16];
    logic signed [31:0]       vx [16];
    logic signed [31:0]       vy [16];
    logic signed [31:0]       vz [16];
    nvs_pkg::nvs_out_t        pending [$];
    int                       errors;
    int                       checked;

    function void wipe_store();
        foreach (used[i]) used[i] = 0;
    endfunction

    function int find_slot(logic [62:0] key);
        for (int i = 0; i < 16; i++)
            if (used[i] && name[i] == key) return i;
        return -1;
    endfunction

    function logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // product then arithmetic shift floors toward minus infinity
    function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] f);
        longint p;
        p = longint'(a) * longint'(f);
        return sat(p >>> 16);
    endfunction

    function void push(logic [2:0] st, int slot, logic [62:0] key,
                       logic signed [31:0] x, logic signed [31:0] y,
                       logic signed [31:0] z, bit lst);
        nvs_pkg::nvs_out_t r;
        r.status = st;
        r.slot_index = (slot < 0) ? 4'd0 : slot[3:0];
        r.out_key = key;
        r.out_x = x;
        r.out_y = y;
        r.out_z = z;
        r.last = lst;
        pending.push_back(r);
    endfunction

    // note one accepted command and queue what it must produce
    function void note_command(nvs_pkg::nvs_in_t c);
        int ia, ib, s, n;
        logic signed [31:0] x, y, z;
        case (c.cmd)
            nvs_pkg::CMD_DEFINE, nvs_pkg::CMD_ADD, nvs_pkg::CMD_SUB,
            nvs_pkg::CMD_SCALE:
            begin
                if (c.cmd == nvs_pkg::CMD_DEFINE) begin
                    x = c.val_x; y = c.val_y; z = c.val_z;
                end else if (c.cmd == nvs_pkg::CMD_SCALE) begin
                    ia = find_slot(c.src_a_key);
                    if (ia < 0) begin
                        push(nvs_pkg::STAT_NOTFOUND, -1, c.dest_key, 0, 0, 0, 1);
                        return;
                    end
                    x = qmul(vx[ia], c.factor);
                    y = qmul(vy[ia], c.factor);
                    z = qmul(vz[ia], c.factor);
                end else begin
                    ia = find_slot(c.src_a_key);
                    ib = find_slot(c.src_b_key);
                    if (ia < 0 || ib < 0) begin
                        push(nvs_pkg::STAT_NOTFOUND, -1, c.dest_key, 0, 0, 0, 1);
                        return;
                    end
                    if (c.cmd == nvs_pkg::CMD_ADD) begin
                        x = sat(longint'(vx[ia]) + longint'(vx[ib]));
                        y = sat(longint'(vy[ia]) + longint'(vy[ib]));
                        z = sat(longint'(vz[ia]) + longint'(vz[ib]));
                    end else begin
                        x = sat(longint'(vx[ia]) - longint'(vx[ib]));
                        y = sat(longint'(vy[ia]) - longint'(vy[ib]));
                        z = sat(longint'(vz[ia]) - longint'(vz[ib]));
                    end
                end
                s = find_slot(c.dest_key);
                if (s < 0) begin
                    for (int i = 0; i < 16; i++)
                        if (!used[i]) begin s = i; break; end
                    if (s >= 0) begin used[s] = 1; name[s] = c.dest_key; end
                end
                if (s >= 0) begin vx[s] = x; vy[s] = y; vz[s] = z; end
                push(s < 0 ? nvs_pkg::STAT_FULL : nvs_pkg::STAT_OK, s, c.dest_key,
                     x, y, z, 1);
            end
            nvs_pkg::CMD_CLEAR:
            begin
                wipe_store();
                push(nvs_pkg::STAT_OK, -1, 0, 0, 0, 0, 1);
            end
            nvs_pkg::CMD_SHOW:
            begin
                ia = find_slot(c.src_a_key);
                if (ia < 0) push(nvs_pkg::STAT_NOTFOUND, -1, c.src_a_key, 0, 0, 0, 1);
                else push(nvs_pkg::STAT_OK, ia, name[ia], vx[ia], vy[ia], vz[ia], 1);
            end
            nvs_pkg::CMD_LIST:
            begin
                n = 0;
                for (int i = 0; i < 16; i++)
                    if (used[i]) begin
                        push(nvs_pkg::STAT_OK, i, name[i], vx[i], vy[i], vz[i], 0);
                        n++;
                    end
                if (n == 0) push(nvs_pkg::STAT_EMPTY, -1, 0, 0, 0, 0, 1);
                else pending[pending.size()-1].last = 1;
            end
            default:
                push(nvs_pkg::STAT_BADCMD, -1, 0, 0, 0, 0, 1);
        endcase
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(nvs_pkg::nvs_out_t r);
        nvs_pkg::nvs_out_t e;
        checked++;
        if (pending.size() == 0) begin
            report("unexpected result", 64'(r.out_key), 64'd0);
            return;
        end
        e = pending.pop_front();
        if (r.status !== e.status)
            report("status", 64'(r.status), 64'(e.status));
        if (r.slot_index !== e.slot_index)
            report("slot_index", 64'(r.slot_index), 64'(e.slot_index));
        if (r.out_key !== e.out_key)
            report("out_key", 64'(r.out_key), 64'(e.out_key));
        if (r.out_x !== e.out_x)
            report("out_x", 64'($unsigned(r.out_x)), 64'($unsigned(e.out_x)));
        if (r.out_y !== e.out_y)
            report("out_y", 64'($unsigned(r.out_y)), 64'($unsigned(e.out_y)));
        if (r.out_z !== e.out_z)
            report("out_z", 64'($unsigned(r.out_z)), 64'($unsigned(e.out_z)));
        if (r.last !== e.last)
            report("last", 64'(r.last), 64'(e.last));
    endfunction
endclass

module tb_named_vector_store_alu;
    import nvs_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    nvs_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    nvs_out_t out_data;

    // idle percentages for sender and receiver, changed per phase
    int       send_idle;
    int       recv_idle;
    int       sent;
    nvs_scoreboard board;

    // small pool of names so lookups often hit
    logic [62:0] names [8];

    named_vector_store_alu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // run limit: generous bound over the slowest legal run
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stall, check on each result transfer
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) board.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one command transfer, with a random gap first; valid stays up until the
    // next command or a drain drops it
    task automatic send(nvs_in_t c);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_command(c);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(65536 * 4) - 65536 * 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [62:0] rnd_key();
        if ($urandom_range(9) < 8) return names[$urandom_range(7)];
        return 63'({$urandom, $urandom});
    endfunction

    function automatic nvs_in_t make_cmd(logic [2:0] op, logic [62:0] d, logic [62:0] a,
                                         logic [62:0] b);
        nvs_in_t c;
        c.cmd = op; c.dest_key = d; c.src_a_key = a; c.src_b_key = b;
        c.val_x = rnd_val(); c.val_y = rnd_val(); c.val_z = rnd_val();
        c.factor = rnd_val();
        return c;
    endfunction

    // mostly valid commands over the name pool, some noise and bad codes
    task automatic random_items(int count);
        logic [2:0] op;
        nvs_in_t c;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: op = CMD_DEFINE;
                6, 7: op = CMD_ADD;
                8, 9: op = CMD_SUB;
                10, 11, 12: op = CMD_SCALE;
                13: op = ($urandom_range(3) == 0) ? CMD_CLEAR : CMD_SHOW;
                14, 15, 16: op = CMD_SHOW;
                17, 18: op = CMD_LIST;
                default: op = ($urandom_range(1) == 0) ? CMD_BAD : CMD_DEFINE;
            endcase
            c = make_cmd(op, rnd_key(), rnd_key(), rnd_key());
            if ($urandom_range(30) == 0) c = {$urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom};
            send(c);
        end
    endtask

    initial
    begin
        nvs_in_t c;
        board = new();
        board.wipe_store();
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        in_data = '0;
        send_idle = 34;
        recv_idle = 46;
        sent = 0;
        for (int i = 0; i < 8; i++) names[i] = 63'({$urandom, $urandom}) | 63'h1;
        names[0] = '0;
        names[1] = {63{1'b1}};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty list, misses, extremes, saturation, fill, full, bad code
        send(make_cmd(CMD_LIST, 0, 0, 0));
        send(make_cmd(CMD_SHOW, 0, names[2], 0));
        send(make_cmd(CMD_ADD, names[2], names[3], names[4]));
        send(make_cmd(CMD_SCALE, names[2], names[3], 0));
        c = make_cmd(CMD_DEFINE, names[0], 0, 0);
        c.val_x = 32'h7fffffff; c.val_y = 32'h80000000; c.val_z = 32'hffffffff;
        send(c);
        c = make_cmd(CMD_DEFINE, names[1], 0, 0);
        c.val_x = 32'h7fffffff; c.val_y = 32'h80000000; c.val_z = 32'h00010000;
        send(c);
        send(make_cmd(CMD_ADD, names[2], names[0], names[1]));
        send(make_cmd(CMD_SUB, names[3], names[0], names[1]));
        c = make_cmd(CMD_SCALE, names[4], names[0], 0);
        c.factor = 32'h80000000;
        send(c);
        c.factor = 32'hffff8000; c.dest_key = names[5];
        send(c);
        c.factor = 32'h7fffffff; c.src_a_key = names[1];
        send(c);
        send(make_cmd(CMD_SHOW, 0, names[1], 0));
        for (int i = 0; i < 11; i++)
            send(make_cmd(CMD_DEFINE, 63'({$urandom, $urandom}), 0, 0));
        send(make_cmd(CMD_DEFINE, names[7], 0, 0));
        send(make_cmd(CMD_LIST, 0, 0, 0));
        send(make_cmd(CMD_BAD, 0, 0, 0));
        send(make_cmd(CMD_CLEAR, 0, 0, 0));
        send(make_cmd(CMD_LIST, 0, 0, 0));

        // sender holds off until everything has drained
        wait_drained();
        random_items(102);
        send_idle = 46;
        recv_idle = 34;
        random_items(102);
        send_idle = 0;
        recv_idle = 0;
        random_items(102);

        wait_drained();
        repeat (200) @(posedge clk);
        $display("ran %0d commands, %0d result transfers checked", sent, board.checked);
        $display("covered define/add/sub/scale/clear/show/list, full store and bad codes");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
src/nvs_pkg.sv
src/nvs_lane.sv
src/named_vector_store_alu.sv
dv/tb_named_vector_store_alu.sv
